// File: design/daily_window_min_max_tracker_assert.svh
// Assertion macros used by the update engine of the daily window min/max tracker.
`ifndef DAILY_WINDOW_MIN_MAX_TRACKER_ASSERT_SVH
`define DAILY_WINDOW_MIN_MAX_TRACKER_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define DWMM_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define DWMM_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DWMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/dwmm_pkg.sv
// Shared types and constants of the daily window min/max tracker.
`default_nettype none

package dwmm_pkg;

  localparam int StampW = 27;
  localparam int ValueW = 32;
  localparam int CountW = 7;

  // Sequencer states of the update engine
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // One finished result beat handed from the engine to the output register
  typedef struct packed {
    logic                     accepted;
    logic [CountW-1:0]        point_count;
    logic signed [ValueW-1:0] window_min;
    logic signed [ValueW-1:0] window_max;
    logic signed [ValueW-1:0] latest_value;
  } res_t;

endpackage

`default_nettype wire

// File: design/dwmm_mem.sv
// Simple dual-port window memory: one write port, one registered read port.
`default_nettype none

module dwmm_mem #(
  parameter int Depth = 64,
  parameter int Width = 59,
  parameter int AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/dwmm_ctrl.sv
// Update engine: stamp lookup, read-modify-write of the ring and min/max rescan.
`default_nettype none
`include "daily_window_min_max_tracker_assert.svh"

module dwmm_ctrl #(
  parameter int WINDOW_POINTS = 64,
  parameter int IdxW          = 6,
  parameter int CntW          = 7
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input beat
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [dwmm_pkg::StampW-1:0]      day_stamp_i,
  input  logic signed [dwmm_pkg::ValueW-1:0] sample_value_i,
  // result handoff
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output dwmm_pkg::res_t                   res_o,
  // memory
  output logic                             mem_we_o,
  output logic [IdxW-1:0]                  mem_waddr_o,
  output logic [dwmm_pkg::StampW+dwmm_pkg::ValueW-1:0] mem_wdata_o,
  output logic [IdxW-1:0]                  mem_raddr_o,
  input  logic [dwmm_pkg::StampW+dwmm_pkg::ValueW-1:0] mem_rdata_i
);

  import dwmm_pkg::*;

  localparam logic [CntW-1:0] FullCnt = CntW'(WINDOW_POINTS);

  // ring index: (base + off) mod WINDOW_POINTS, both operands below the depth
  function automatic logic [IdxW-1:0] ring_add(input logic [IdxW-1:0] base,
                                               input logic [IdxW-1:0] off);
    logic [IdxW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IdxW+1)'(WINDOW_POINTS)) begin
      sum = sum - (IdxW+1)'(WINDOW_POINTS);
    end
    return sum[IdxW-1:0];
  endfunction

  state_e                   state_q, state_d;
  logic [StampW-1:0]        stamp_q, stamp_d;
  logic signed [ValueW-1:0] value_q, value_d;
  logic [IdxW-1:0]          newest_q, newest_d;
  logic [IdxW-1:0]          oldest_q, oldest_d;
  logic [CntW-1:0]          fill_q, fill_d;
  logic signed [ValueW-1:0] latest_q, latest_d;
  logic signed [ValueW-1:0] min_q, min_d;
  logic signed [ValueW-1:0] max_q, max_d;
  logic                     acc_q, acc_d;
  logic [IdxW-1:0]          scan_addr_q, scan_addr_d;
  logic [CntW-1:0]          scan_left_q, scan_left_d;
  logic                     rd_vld_q, rd_vld_d;
  logic                     first_q, first_d;

  logic                     in_beat;
  logic                     positive;
  logic [StampW-1:0]        rd_stamp;
  logic signed [ValueW-1:0] rd_value;
  logic                     hit;
  logic [IdxW-1:0]          newest_idx;

  assign in_beat    = in_valid_i & in_ready_o;
  assign positive   = !sample_value_i[ValueW-1] && (sample_value_i != '0);
  assign rd_stamp   = mem_rdata_i[StampW+ValueW-1:ValueW];
  assign rd_value   = mem_rdata_i[ValueW-1:0];
  assign hit        = (fill_q != '0) && (rd_stamp == stamp_q);
  assign newest_idx = ring_add(oldest_q, IdxW'(fill_q - CntW'(1)));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          state_d = positive ? ST_UPDATE : ST_DONE;
        end
      end
      ST_UPDATE: state_d = ST_SCAN;
      ST_SCAN: begin
        if (scan_left_q == CntW'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake and memory port outputs
  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_raddr_o = scan_addr_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        mem_raddr_o = newest_idx;
      end
      ST_UPDATE: mem_we_o = 1'b1;
      ST_SCAN:   mem_raddr_o = scan_addr_q;
      ST_DRAIN:  mem_raddr_o = scan_addr_q;
      ST_DONE:   res_valid_o = 1'b1;
      default:   mem_we_o = 1'b0;
    endcase
  end

  // write slot: overwrite newest on a repeated stamp, else append or replace oldest
  always_comb begin
    if (hit) begin
      mem_waddr_o = newest_q;
    end else if (fill_q < FullCnt) begin
      mem_waddr_o = ring_add(oldest_q, IdxW'(fill_q));
    end else begin
      mem_waddr_o = oldest_q;
    end
  end
  assign mem_wdata_o = {stamp_q, value_q};

  // datapath next values
  always_comb begin
    stamp_d     = stamp_q;
    value_d     = value_q;
    newest_d    = newest_q;
    oldest_d    = oldest_q;
    fill_d      = fill_q;
    latest_d    = latest_q;
    min_d       = min_q;
    max_d       = max_q;
    acc_d       = acc_q;
    scan_addr_d = scan_addr_q;
    scan_left_d = scan_left_q;
    rd_vld_d    = 1'b0;
    first_d     = first_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          stamp_d  = day_stamp_i;
          value_d  = sample_value_i;
          newest_d = newest_idx;
          acc_d    = positive;
        end
      end
      ST_UPDATE: begin
        if (!hit) begin
          if (fill_q < FullCnt) begin
            fill_d = fill_q + CntW'(1);
          end else begin
            oldest_d = ring_add(oldest_q, IdxW'(1));
          end
        end
        latest_d    = value_q;
        scan_addr_d = oldest_d;
        scan_left_d = fill_d;
        first_d     = 1'b1;
      end
      ST_SCAN: begin
        rd_vld_d    = 1'b1;
        scan_addr_d = ring_add(scan_addr_q, IdxW'(1));
        scan_left_d = scan_left_q - CntW'(1);
      end
      default: rd_vld_d = 1'b0;
    endcase

    // fold the value returned by the previous scan read
    if (rd_vld_q) begin
      first_d = 1'b0;
      if (first_q) begin
        min_d = rd_value;
        max_d = rd_value;
      end else begin
        if (rd_value < min_q) min_d = rd_value;
        if (rd_value > max_q) max_d = rd_value;
      end
    end
  end

  // control and held state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      oldest_q    <= '0;
      fill_q      <= '0;
      latest_q    <= '0;
      min_q       <= '0;
      max_q       <= '0;
      acc_q       <= 1'b0;
      scan_left_q <= '0;
      rd_vld_q    <= 1'b0;
      first_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      oldest_q    <= oldest_d;
      fill_q      <= fill_d;
      latest_q    <= latest_d;
      min_q       <= min_d;
      max_q       <= max_d;
      acc_q       <= acc_d;
      scan_left_q <= scan_left_d;
      rd_vld_q    <= rd_vld_d;
      first_q     <= first_d;
    end
  end

  // item payload and scan address
  always_ff @(posedge clk_i) begin
    stamp_q     <= stamp_d;
    value_q     <= value_d;
    newest_q    <= newest_d;
    scan_addr_q <= scan_addr_d;
  end

  assign res_o.accepted     = acc_q;
  assign res_o.point_count  = CountW'(fill_q);
  assign res_o.window_min   = min_q;
  assign res_o.window_max   = max_q;
  assign res_o.latest_value = latest_q;

  `DWMM_ASSERT_ALWAYS(a_fill_bound, clk_i, rst_ni, fill_q <= FullCnt, "fill count above window")
  `DWMM_ASSERT_IMPLIES(a_ring_only_when_full, clk_i, rst_ni, oldest_q != '0, fill_q == FullCnt, "oldest pointer moved before window full")
  `DWMM_ASSERT_IMPLIES(a_scan_nonempty, clk_i, rst_ni, state_q == ST_SCAN, scan_left_q != '0, "scan with no entries left")
  `DWMM_ASSERT_IMPLIES(a_min_le_max, clk_i, rst_ni, state_q == ST_DONE && acc_q, min_q <= max_q, "window min above window max")
  `DWMM_ASSERT_NEXT(a_done_to_idle, clk_i, rst_ni, state_q == ST_DONE && res_ready_i, state_q == ST_IDLE, "result handoff did not return to idle")

endmodule

`default_nettype wire

// File: design/daily_window_min_max_tracker.sv
// Flow: a positive sample passes through a write state, a rescan that reads every held
// entry, a drain state and the result handoff; other samples go straight to the handoff.
// The engine takes no new sample until the last result has been handed off; the single
// read port of the window memory is walked once per update.
// Reset: asynchronous, active low; clears count, ring pointer and held values.
// Memory contents are not cleared; only written entries are ever used.
`default_nettype none

module daily_window_min_max_tracker #(
  parameter int WINDOW_POINTS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [dwmm_pkg::StampW-1:0]        day_stamp_i,
  input  logic signed [dwmm_pkg::ValueW-1:0] sample_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               accepted_o,
  output logic [dwmm_pkg::CountW-1:0]        point_count_o,
  output logic signed [dwmm_pkg::ValueW-1:0] window_min_o,
  output logic signed [dwmm_pkg::ValueW-1:0] window_max_o,
  output logic signed [dwmm_pkg::ValueW-1:0] latest_value_o
);

  import dwmm_pkg::*;

  localparam int IdxW  = $clog2(WINDOW_POINTS);
  localparam int CntW  = $clog2(WINDOW_POINTS + 1);
  localparam int WordW = StampW + ValueW;

  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  logic [WordW-1:0] mem_wdata;
  logic [IdxW-1:0]  mem_raddr;
  logic [WordW-1:0] mem_rdata;

  logic             out_valid_q, out_valid_d;
  res_t             out_q;

  dwmm_ctrl #(
    .WINDOW_POINTS(WINDOW_POINTS),
    .IdxW         (IdxW),
    .CntW         (CntW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .day_stamp_i   (day_stamp_i),
    .sample_value_i(sample_value_i),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  dwmm_mem #(
    .Depth(WINDOW_POINTS),
    .Width(WordW),
    .AddrW(IdxW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // output register: loads when empty or being drained this cycle
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = out_q.accepted;
  assign point_count_o  = out_q.point_count;
  assign window_min_o   = out_q.window_min;
  assign window_max_o   = out_q.window_max;
  assign latest_value_o = out_q.latest_value;

endmodule

`default_nettype wire

// File: tb/tb_daily_window_min_max_tracker.sv
// Self-checking testbench for the daily window min/max tracker.
`timescale 1ns / 100ps

module tb_daily_window_min_max_tracker;

  localparam int WindowPoints = 64;
  localparam int LastDay      = 99991231;
  localparam int TargetItems  = 1900;
  localparam int StampW       = dwmm_pkg::StampW;

  // Tracks the sliding window of daily samples and checks every result beat in order
  class window_extrema_board #(int Depth = 64);
    logic [dwmm_pkg::StampW-1:0]        stamp_ring[Depth];
    logic signed [dwmm_pkg::ValueW-1:0] value_ring[Depth];
    int unsigned                        oldest_idx;
    int unsigned                        fill_cnt;
    logic signed [dwmm_pkg::ValueW-1:0] latest_val;
    logic signed [dwmm_pkg::ValueW-1:0] min_val;
    logic signed [dwmm_pkg::ValueW-1:0] max_val;
    dwmm_pkg::res_t                     expected_summaries[$];
    int unsigned                        mismatches;

    function new();
      oldest_idx = 0;
      fill_cnt   = 0;
      latest_val = '0;
      min_val    = '0;
      max_val    = '0;
      mismatches = 0;
    endfunction

    // Apply one accepted input beat to the window and queue the summary it yields
    function void note_sample(logic [dwmm_pkg::StampW-1:0] stamp,
                              logic signed [dwmm_pkg::ValueW-1:0] sample);
      int unsigned    newest_idx;
      int unsigned    slot;
      dwmm_pkg::res_t summary;
      if (sample > 0) begin
        newest_idx = (oldest_idx + fill_cnt + Depth - 1) % Depth;
        if (fill_cnt != 0 && stamp_ring[newest_idx] == stamp) begin
          // same day as the newest point: overwrite in place
          value_ring[newest_idx] = sample;
        end else if (fill_cnt < Depth) begin
          slot = (oldest_idx + fill_cnt) % Depth;
          stamp_ring[slot] = stamp;
          value_ring[slot] = sample;
          fill_cnt++;
        end else begin
          // full: replace the oldest point and advance the ring
          stamp_ring[oldest_idx] = stamp;
          value_ring[oldest_idx] = sample;
          oldest_idx = (oldest_idx + 1) % Depth;
        end
        latest_val = sample;
        // rescan every held point, signed compare
        min_val = value_ring[oldest_idx];
        max_val = value_ring[oldest_idx];
        for (int unsigned k = 1; k < fill_cnt; k++) begin
          if (value_ring[(oldest_idx + k) % Depth] < min_val)
            min_val = value_ring[(oldest_idx + k) % Depth];
          if (value_ring[(oldest_idx + k) % Depth] > max_val)
            max_val = value_ring[(oldest_idx + k) % Depth];
        end
      end
      summary.accepted     = (sample > 0);
      summary.point_count  = fill_cnt[dwmm_pkg::CountW-1:0];
      summary.window_min   = min_val;
      summary.window_max   = max_val;
      summary.latest_value = latest_val;
      expected_summaries.push_back(summary);
    endfunction

    // Compare one result beat against the oldest queued summary
    function void check_beat(dwmm_pkg::res_t got);
      dwmm_pkg::res_t want;
      if (expected_summaries.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: acc=%0d cnt=%0d min=%0d max=%0d last=%0d",
                   got.accepted, got.point_count, $signed(got.window_min),
                   $signed(got.window_max), $signed(got.latest_value));
        return;
      end
      want = expected_summaries.pop_front();
      if (got.accepted !== want.accepted || got.point_count !== want.point_count ||
          got.window_min !== want.window_min || got.window_max !== want.window_max ||
          got.latest_value !== want.latest_value) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: expected acc=%0d cnt=%0d min=%0d max=%0d last=%0d,",
                    " got acc=%0d cnt=%0d min=%0d max=%0d last=%0d"},
                   want.accepted, want.point_count, $signed(want.window_min),
                   $signed(want.window_max), $signed(want.latest_value),
                   got.accepted, got.point_count, $signed(got.window_min),
                   $signed(got.window_max), $signed(got.latest_value));
      end
    endfunction
  endclass

  typedef window_extrema_board #(WindowPoints) board_t;

  logic                               clk_i          = 1'b0;
  logic                               rst_ni         = 1'b0;
  logic                               in_valid_i     = 1'b0;
  logic                               in_ready_o;
  logic [dwmm_pkg::StampW-1:0]        day_stamp_i    = '0;
  logic signed [dwmm_pkg::ValueW-1:0] sample_value_i = '0;
  logic                               out_valid_o;
  logic                               out_ready_i    = 1'b0;
  logic                               accepted_o;
  logic [dwmm_pkg::CountW-1:0]        point_count_o;
  logic signed [dwmm_pkg::ValueW-1:0] window_min_o;
  logic signed [dwmm_pkg::ValueW-1:0] window_max_o;
  logic signed [dwmm_pkg::ValueW-1:0] latest_value_o;

  board_t board = new();

  int unsigned sent_items = 0;
  int unsigned burst_left = 0;
  int unsigned ready_hold = 0;

  daily_window_min_max_tracker #(
    .WINDOW_POINTS(WindowPoints)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .day_stamp_i   (day_stamp_i),
    .sample_value_i(sample_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .accepted_o    (accepted_o),
    .point_count_o (point_count_o),
    .window_min_o  (window_min_o),
    .window_max_o  (window_max_o),
    .latest_value_o(latest_value_o)
  );

  always #2 clk_i = ~clk_i;

  // Sender idle length: mostly none or short, a few long, occasional bursts
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // Positive Q16.16 values, weighted toward the extremes and small magnitudes
  function automatic logic signed [31:0] positive_sample();
    int unsigned        r;
    logic signed [31:0] v;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'sd1;
    if (r < 20) return 32'sh7FFF_FFFF;
    if (r < 50) return $urandom_range(1, 32'h0010_0000);
    v = $urandom & 32'h7FFF_FFFF;
    return (v == 0) ? 32'sd1 : v;
  endfunction

  // Zero or negative values, which the block ignores
  function automatic logic signed [31:0] nonpositive_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return 32'sd0;
    if (r < 40) return 32'sh8000_0000;
    return $urandom | 32'h8000_0000;
  endfunction

  // Present one input beat and hold it until the block takes it
  task automatic drive_sample(input logic [dwmm_pkg::StampW-1:0] stamp,
                              input logic signed [dwmm_pkg::ValueW-1:0] sample);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    day_stamp_i    <= stamp;
    sample_value_i <= sample;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_sample(stamp, sample);
    sent_items++;
  endtask

  // Hold off the sender until every queued result has come back
  task automatic drain_pause();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.expected_summaries.size() != 0);
  endtask

  // Result monitor and receiver stall pattern
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_beat('{accepted_o, point_count_o, window_min_o, window_max_o,
                         latest_value_o});
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (out_ready_i) begin
      out_ready_i <= 1'b0;
      case ($urandom_range(0, 19))
        0:       ready_hold = $urandom_range(20, 60) - 1;
        1, 2, 3: ready_hold = $urandom_range(4, 10) - 1;
        default: ready_hold = $urandom_range(1, 3) - 1;
      endcase
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 9) < 2) ready_hold = $urandom_range(100, 400) - 1;
      else ready_hold = $urandom_range(1, 10) - 1;
    end
  end

  // Stimulus
  initial begin
    int unsigned                 r;
    int unsigned                 run_len;
    logic [dwmm_pkg::StampW-1:0] day;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: ignored values on an empty window
    drive_sample(27'd20240101, 32'sd0);
    drive_sample(27'd20240101, 32'sh8000_0000);
    // smallest positive, then overwrite on the same day with the largest
    drive_sample(27'd0, 32'sd1);
    drive_sample(27'd0, 32'sh7FFF_FFFF);
    drive_sample(27'd0, -32'sd1);
    // last calendar day appended, then overwritten downward
    drive_sample(StampW'(LastDay), 32'sh0001_0000);
    drive_sample(StampW'(LastDay), 32'sh0000_8000);
    // repeat of an older stamp is appended, not merged
    drive_sample(27'd0, 32'sd5);
    drive_sample(27'd20240102, 32'sh7FFF_FFFF);
    drive_sample(27'd20240103, 32'sd1);
    drive_sample(27'd20240103, 32'sd0);
    drive_sample(27'd20240104, 32'sh8000_0000);
    drive_sample(27'd20240104, 32'sh0000_0003);
    drive_sample(27'd20240104, 32'sh0000_0002);
    drain_pause();

    // random: mostly runs of ascending days, with noise and ignored bursts
    day = StampW'($urandom_range(0, LastDay));
    while (sent_items < TargetItems) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        run_len = $urandom_range(5, 40);
        for (int unsigned k = 0; k < run_len; k++) begin
          r = $urandom_range(0, 99);
          if (r < 4) begin
            drive_sample(day, nonpositive_sample());
          end else begin
            if (k == 0 || r >= 16) day = (day >= LastDay) ? 27'd0 : day + 27'd1;
            drive_sample(day, positive_sample());
          end
        end
      end else if (r < 90) begin
        run_len = $urandom_range(1, 6);
        for (int unsigned k = 0; k < run_len; k++) begin
          if ($urandom_range(0, 1) == 0) day = StampW'($urandom_range(0, LastDay));
          drive_sample(day, $urandom);
        end
      end else if (r < 97) begin
        run_len = $urandom_range(1, 5);
        for (int unsigned k = 0; k < run_len; k++)
          drive_sample(StampW'($urandom_range(0, LastDay)), nonpositive_sample());
      end else begin
        drain_pause();
      end
    end

    // wind down: let the block finish and catch any stray beats
    in_valid_i <= 1'b0;
    while (board.expected_summaries.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (board.mismatches == 0 && board.expected_summaries.size() == 0) begin
      $display("daily_window_min_max_tracker verification clean");
    end else begin
      $display("daily_window_min_max_tracker verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("daily_window_min_max_tracker verification failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/dwmm_pkg.sv
design/dwmm_mem.sv
design/dwmm_ctrl.sv
design/daily_window_min_max_tracker.sv
tb/tb_daily_window_min_max_tracker.sv
